// ----- hw/rtl/lmd_pkg.sv -----
// Shared types and constants for the Lorentz motion derivative pipeline.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package lmd_pkg;

    // Vector geometry and fixed-point widths.
    localparam int LANES       = 3;
    localparam int WORD_W      = 32;
    localparam int RAD_W       = 64;
    localparam int SQRT_STAGES = 32;
    localparam int QUO_W       = 31;
    localparam int NUM_W       = 62;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EQUATION_MODE = 2'd0,
        CFG_REVERSE_TIME  = 2'd1,
        CFG_FORCE_COEF    = 2'd2
    } t_cfg_idx;

    // Equation mode code for motion along the field line.
    localparam logic MODE_FIELD_LINE = 1'b1;

    // Reset value of the force coefficient, 1.0 in Q16.16.
    localparam logic [WORD_W-1:0] COEF_RESET = 32'h0001_0000;

    typedef logic [LANES-1:0][WORD_W-1:0] t_vec;

    // Data that rides alongside the square root.
    typedef struct packed {
        t_vec              mag;
        logic [LANES-1:0]  sgn;
        t_vec              field;
    } t_root_side;

    // Data that rides alongside the divider.
    typedef struct packed {
        logic [LANES-1:0]  sgn;
        t_vec              field;
        logic              zero;
    } t_div_side;

    // Data that rides alongside the force unit.
    typedef struct packed {
        t_vec              dir;
        logic              zero;
    } t_force_side;

    // One finished result beat.
    typedef struct packed {
        t_vec              dir;
        t_vec              frc;
        logic              zero;
        logic              sat;
    } t_result;

endpackage

// ----- hw/rtl/lmd_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a sideband payload.
// Depends on lmd_pkg for widths and stage count.
module lmd_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [lmd_pkg::RAD_W-1:0]       i_rad,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    output logic [lmd_pkg::WORD_W-1:0]      o_root,
    output logic [SIDE_W-1:0]               o_side
);

    localparam int STAGES = lmd_pkg::SQRT_STAGES;
    localparam int RW     = lmd_pkg::RAD_W;

    logic [RW-1:0]     w_x    [STAGES+1];
    logic [RW-1:0]     w_r    [STAGES+1];
    logic [STAGES:0]   w_vld;
    logic [SIDE_W-1:0] w_side [STAGES+1];

    assign w_x[0]    = i_rad;
    assign w_r[0]    = '0;
    assign w_vld[0]  = i_valid;
    assign w_side[0] = i_side;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);

            logic [RW-1:0]     trial;
            logic [RW-1:0]     n_x;
            logic [RW-1:0]     n_r;
            logic [RW-1:0]     r_x;
            logic [RW-1:0]     r_r;
            logic              r_vld;
            logic [SIDE_W-1:0] r_side;

            // One digit of the restoring square root.
            always_comb begin
                trial = w_r[k] + BIT;
                if (w_x[k] >= trial) begin
                    n_x = w_x[k] - trial;
                    n_r = (w_r[k] >> 1) + BIT;
                end else begin
                    n_x = w_x[k];
                    n_r = w_r[k] >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld <= 1'b0;
                end else if (i_en) begin
                    r_vld <= w_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x    <= n_x;
                    r_r    <= n_r;
                    r_side <= w_side[k];
                end
            end

            assign w_x[k+1]    = r_x;
            assign w_r[k+1]    = r_r;
            assign w_vld[k+1]  = r_vld;
            assign w_side[k+1] = r_side;
        end
    endgenerate

    assign o_valid = w_vld[STAGES];
    assign o_root  = w_r[STAGES][lmd_pkg::WORD_W-1:0];
    assign o_side  = w_side[STAGES];

endmodule

// ----- hw/rtl/lmd_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on lmd_pkg for lane count and widths.
module lmd_div #(
    parameter int SIDE_W = 1
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_en,
    input  logic                                                i_valid,
    input  logic [lmd_pkg::WORD_W-1:0]                          i_den,
    input  logic [lmd_pkg::LANES-1:0][lmd_pkg::NUM_W-1:0]       i_num,
    input  logic [SIDE_W-1:0]                                   i_side,
    output logic                                                o_valid,
    output logic [lmd_pkg::LANES-1:0][lmd_pkg::QUO_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]                                   o_side
);

    localparam int STEPS = lmd_pkg::QUO_W;
    localparam int L     = lmd_pkg::LANES;
    localparam int W     = lmd_pkg::WORD_W;

    logic [L-1:0][W-1:0]     w_rem  [STEPS+1];
    logic [L-1:0][STEPS-1:0] w_low  [STEPS+1];
    logic [L-1:0][STEPS-1:0] w_quo  [STEPS+1];
    logic [W-1:0]            w_den  [STEPS+1];
    logic [STEPS:0]          w_vld;
    logic [SIDE_W-1:0]       w_side [STEPS+1];

    // The quotient fits in QUO_W bits, so the top numerator bits start as the remainder.
    genvar l;
    generate
        for (l = 0; l < L; l++) begin : g_init
            assign w_rem[0][l] = W'(i_num[l][lmd_pkg::NUM_W-1:STEPS]);
            assign w_low[0][l] = i_num[l][STEPS-1:0];
            assign w_quo[0][l] = '0;
        end
    endgenerate

    assign w_den[0]  = i_den;
    assign w_vld[0]  = i_valid;
    assign w_side[0] = i_side;

    genvar j;
    generate
        for (j = 0; j < STEPS; j++) begin : g_step
            logic [L-1:0][W-1:0]     n_rem;
            logic [L-1:0][STEPS-1:0] n_quo;
            logic [L-1:0][W-1:0]     r_rem;
            logic [L-1:0][STEPS-1:0] r_low;
            logic [L-1:0][STEPS-1:0] r_quo;
            logic [W-1:0]            r_den;
            logic                    r_vld;
            logic [SIDE_W-1:0]       r_side;

            // Bring down the next numerator bit and subtract where it fits.
            always_comb begin
                logic [W:0] t;
                logic       ge;
                for (int m = 0; m < L; m++) begin
                    t  = {w_rem[j][m], w_low[j][m][STEPS-1-j]};
                    ge = (t >= {1'b0, w_den[j]});
                    n_rem[m] = ge ? W'(t - {1'b0, w_den[j]}) : t[W-1:0];
                    n_quo[m] = {w_quo[j][m][STEPS-2:0], ge};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld <= 1'b0;
                end else if (i_en) begin
                    r_vld <= w_vld[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem  <= n_rem;
                    r_low  <= w_low[j];
                    r_quo  <= n_quo;
                    r_den  <= w_den[j];
                    r_side <= w_side[j];
                end
            end

            assign w_rem[j+1]  = r_rem;
            assign w_low[j+1]  = r_low;
            assign w_quo[j+1]  = r_quo;
            assign w_den[j+1]  = r_den;
            assign w_vld[j+1]  = r_vld;
            assign w_side[j+1] = r_side;
        end
    endgenerate

    assign o_valid = w_vld[STEPS];
    assign o_quo   = w_quo[STEPS];
    assign o_side  = w_side[STEPS];

endmodule

// ----- hw/rtl/lmd_force.sv -----
// Force unit: cross product of direction and field, scaled by the coefficient,
// rounded and saturated over four register stages. Depends on lmd_pkg.
module lmd_force #(
    parameter int SIDE_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  lmd_pkg::t_vec                   i_dir,
    input  lmd_pkg::t_vec                   i_field,
    input  logic [lmd_pkg::WORD_W-1:0]      i_coef,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    output lmd_pkg::t_vec                   o_frc,
    output logic [lmd_pkg::LANES-1:0]       o_sat,
    output logic [SIDE_W-1:0]               o_side
);

    localparam int L = lmd_pkg::LANES;
    localparam int W = lmd_pkg::WORD_W;
    localparam logic [2*W-1:0] HALF_LSB = 64'h0000_2000_0000_0000;

    logic [3:0]        r_vld;
    logic [SIDE_W-1:0] r_side [4];

    logic [W-1:0]      w_cmag;
    logic              w_cneg;

    logic signed [2*W-1:0] r1_pa [L];
    logic signed [2*W-1:0] r1_pb [L];
    logic [2*W-2:0]        r2_ym [L];
    logic [L-1:0]          r2_neg;
    logic [2*W-2:0]        r3_hi [L];
    logic [2*W-1:0]        r3_lo [L];
    logic [L-1:0]          r3_neg;
    lmd_pkg::t_vec         r4_frc;
    logic [L-1:0]          r4_sat;

    // Coefficient magnitude and sign; the user, not the block, keeps the register steady while items are in flight.
    assign w_cneg = i_coef[W-1];
    assign w_cmag = w_cneg ? (~i_coef + 1'b1) : i_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
        end
    end

    genvar l;
    generate
        for (l = 0; l < L; l++) begin : g_lane
            localparam int A = (l + 1) % L;
            localparam int B = (l + 2) % L;

            logic signed [2*W-1:0] y;
            logic [2*W-1:0]        ymag;
            logic [2*W-1:0]        sum;
            logic [2*W-1:0]        rnd;
            logic [W-1:0]          mag;
            logic                  sat;

            // Products of the cross product.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r1_pa[l] <= $signed(i_dir[A]) * $signed(i_field[B]);
                    r1_pb[l] <= $signed(i_dir[B]) * $signed(i_field[A]);
                end
            end

            // Difference, split into magnitude and result sign.
            assign y    = r1_pa[l] - r1_pb[l];
            assign ymag = y[2*W-1] ? (~y + 1'b1) : y;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r2_ym[l]  <= ymag[2*W-2:0];
                    r2_neg[l] <= y[2*W-1] ^ w_cneg;
                end
            end

            // Partial products of magnitude times coefficient.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r3_hi[l]  <= (2*W-1)'(r2_ym[l][2*W-2:W] * w_cmag);
                    r3_lo[l]  <= r2_ym[l][W-1:0] * w_cmag;
                    r3_neg[l] <= r2_neg[l];
                end
            end

            // Round half away from zero at bit 46, then clip to the 32-bit range.
            always_comb begin
                sum = {1'b0, r3_hi[l]} + ((r3_lo[l] + HALF_LSB) >> W);
                rnd = sum >> 14;
                if (r3_neg[l]) begin
                    sat = (rnd > 64'h0000_0000_8000_0000);
                end else begin
                    sat = (rnd > 64'h0000_0000_7FFF_FFFF);
                end
                if (sat) begin
                    mag = r3_neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    mag = rnd[W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r4_frc[l] <= r3_neg[l] ? (~mag + 1'b1) : mag;
                    r4_sat[l] <= sat;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[3];
    assign o_frc   = r4_frc;
    assign o_sat   = r4_sat;
    assign o_side  = r_side[3];

endmodule

// ----- hw/rtl/lorentz_motion_derivative.sv -----
// Lorentz motion derivative: unit direction and cross-product force from momentum and field.
// Depends on lmd_pkg, lmd_isqrt, lmd_div and lmd_force.
//
// Each input beat carries a momentum and a magnetic field vector in signed Q16.16 and
// yields one result beat: the unit direction in Q2.30 and, in Lorentz mode, the force
// coef * (dir x B) rounded and saturated to Q16.16. In field-line mode the direction is
// that of B and the force is zero. A zero-length vector gives zero outputs and raises
// zero_magnitude. The block takes one beat per cycle while the output skid register is
// empty. A beat passes 72 register stages; the 32-stage square root and the 31-stage
// divider set most of this; the other nine are the square and sum stages, the numerator
// and sign stages, the four force stages and the output register.
// A stalled output holds the whole pipeline once the output skid register is full.
// Configuration must be written through i_cfg_we only while no beat is in flight;
// the block itself does not enforce this.
module lorentz_motion_derivative (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lmd_pkg::WORD_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [lmd_pkg::WORD_W-1:0]          i_momentum_x,
    input  logic [lmd_pkg::WORD_W-1:0]          i_momentum_y,
    input  logic [lmd_pkg::WORD_W-1:0]          i_momentum_z,
    input  logic [lmd_pkg::WORD_W-1:0]          i_field_x,
    input  logic [lmd_pkg::WORD_W-1:0]          i_field_y,
    input  logic [lmd_pkg::WORD_W-1:0]          i_field_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lmd_pkg::WORD_W-1:0]          o_dir_x,
    output logic [lmd_pkg::WORD_W-1:0]          o_dir_y,
    output logic [lmd_pkg::WORD_W-1:0]          o_dir_z,
    output logic [lmd_pkg::WORD_W-1:0]          o_force_x,
    output logic [lmd_pkg::WORD_W-1:0]          o_force_y,
    output logic [lmd_pkg::WORD_W-1:0]          o_force_z,
    output logic                                o_zero_magnitude,
    output logic                                o_saturated
);

    localparam int L         = lmd_pkg::LANES;
    localparam int W         = lmd_pkg::WORD_W;
    localparam int ROOT_SW   = $bits(lmd_pkg::t_root_side);
    localparam int DIV_SW    = $bits(lmd_pkg::t_div_side);
    localparam int FORCE_SW  = $bits(lmd_pkg::t_force_side);

    // Configuration registers.
    logic         r_equation_mode;
    logic         r_reverse_time;
    logic [W-1:0] r_force_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_equation_mode <= 1'b0;
            r_reverse_time  <= 1'b0;
            r_force_coef    <= lmd_pkg::COEF_RESET;
        end else if (i_cfg_we) begin
            case (lmd_pkg::t_cfg_idx'(i_cfg_index))
                lmd_pkg::CFG_EQUATION_MODE: begin
                    r_equation_mode <= i_cfg_data[0];
                end
                lmd_pkg::CFG_REVERSE_TIME: begin
                    r_reverse_time <= i_cfg_data[0];
                end
                lmd_pkg::CFG_FORCE_COEF: begin
                    r_force_coef <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Global pipeline advance: every stage moves unless the output skid is occupied.
    logic w_en;
    logic r_skid_valid;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    // Stage 0: pick the vector to normalize, split sign and magnitude, square.
    lmd_pkg::t_vec        w_vsel;
    lmd_pkg::t_vec        w_field_in;
    lmd_pkg::t_root_side  n_s0_side;
    logic                 r_s0_vld;
    logic [2*W-1:0]       r_s0_sq [L];
    lmd_pkg::t_root_side  r_s0_side;

    assign w_field_in = {i_field_z, i_field_y, i_field_x};
    assign w_vsel = (r_equation_mode == lmd_pkg::MODE_FIELD_LINE) ?
                    w_field_in : {i_momentum_z, i_momentum_y, i_momentum_x};

    always_comb begin
        for (int m = 0; m < L; m++) begin
            n_s0_side.sgn[m] = w_vsel[m][W-1];
            n_s0_side.mag[m] = w_vsel[m][W-1] ? (~w_vsel[m] + 1'b1) : w_vsel[m];
        end
        n_s0_side.field = w_field_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int m = 0; m < L; m++) begin
                r_s0_sq[m] <= n_s0_side.mag[m] * n_s0_side.mag[m];
            end
            r_s0_side <= n_s0_side;
        end
    end

    // Stage 1: sum of squares.
    logic                 r_s1_vld;
    logic [2*W-1:0]       r_s1_sum;
    lmd_pkg::t_root_side  r_s1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_sum  <= r_s0_sq[0] + r_s0_sq[1] + r_s0_sq[2];
            r_s1_side <= r_s0_side;
        end
    end

    // Square root of the sum.
    logic                 w_rt_vld;
    logic [W-1:0]         w_root;
    lmd_pkg::t_root_side  w_rt_side;

    lmd_isqrt #(
        .SIDE_W (ROOT_SW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s1_vld),
        .i_rad   (r_s1_sum),
        .i_side  (r_s1_side),
        .o_valid (w_rt_vld),
        .o_root  (w_root),
        .o_side  (w_rt_side)
    );

    // Stage 2: numerators |v| * 2^30 + floor(root / 2) and the zero-length check.
    logic                                  r_s2_vld;
    logic [W-1:0]                          r_s2_den;
    logic [L-1:0][lmd_pkg::NUM_W-1:0]      r_s2_num;
    lmd_pkg::t_div_side                    r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= w_rt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int m = 0; m < L; m++) begin
                r_s2_num[m] <= {w_rt_side.mag[m], 30'b0} +
                               lmd_pkg::NUM_W'(w_root[W-1:1]);
            end
            r_s2_den        <= w_root;
            r_s2_side.sgn   <= w_rt_side.sgn;
            r_s2_side.field <= w_rt_side.field;
            r_s2_side.zero  <= (w_root == '0);
        end
    end

    // Three quotients against the shared magnitude.
    logic                                  w_dv_vld;
    logic [L-1:0][lmd_pkg::QUO_W-1:0]      w_quo;
    lmd_pkg::t_div_side                    w_dv_side;

    lmd_div #(
        .SIDE_W (DIV_SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_vld),
        .i_den   (r_s2_den),
        .i_num   (r_s2_num),
        .i_side  (r_s2_side),
        .o_valid (w_dv_vld),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    // Stage 3: signed direction, negated for backward tracing.
    logic                  r_s3_vld;
    lmd_pkg::t_vec         r_s3_dir;
    lmd_pkg::t_vec         r_s3_field;
    logic                  r_s3_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int m = 0; m < L; m++) begin
                if (w_dv_side.sgn[m] ^ r_reverse_time) begin
                    r_s3_dir[m] <= ~W'(w_quo[m]) + 1'b1;
                end else begin
                    r_s3_dir[m] <= W'(w_quo[m]);
                end
            end
            r_s3_field <= w_dv_side.field;
            r_s3_zero  <= w_dv_side.zero;
        end
    end

    // Cross-product force.
    lmd_pkg::t_force_side  w_fc_in_side;
    lmd_pkg::t_force_side  w_fc_side;
    logic                  w_fc_vld;
    lmd_pkg::t_vec         w_frc;
    logic [L-1:0]          w_sat;

    assign w_fc_in_side.dir  = r_s3_dir;
    assign w_fc_in_side.zero = r_s3_zero;

    lmd_force #(
        .SIDE_W (FORCE_SW)
    ) u_force (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s3_vld),
        .i_dir   (r_s3_dir),
        .i_field (r_s3_field),
        .i_coef  (r_force_coef),
        .i_side  (w_fc_in_side),
        .o_valid (w_fc_vld),
        .o_frc   (w_frc),
        .o_sat   (w_sat),
        .o_side  (w_fc_side)
    );

    // Result assembly: zero length clears dir, force and sat, field-line mode force and sat.
    lmd_pkg::t_result w_item;

    always_comb begin
        w_item.dir  = w_fc_side.dir;
        w_item.frc  = w_frc;
        w_item.zero = w_fc_side.zero;
        w_item.sat  = |w_sat;
        if (w_fc_side.zero) begin
            w_item.dir = '0;
            w_item.frc = '0;
            w_item.sat = 1'b0;
        end else if (r_equation_mode == lmd_pkg::MODE_FIELD_LINE) begin
            w_item.frc = '0;
            w_item.sat = 1'b0;
        end
    end

    // Output register with a skid stage behind it.
    lmd_pkg::t_result r_out;
    lmd_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             w_deliver;
    logic             w_take;

    assign w_deliver = w_en && w_fc_vld;
    assign w_take    = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_valid && !w_take && w_deliver) begin
            r_skid_valid <= 1'b1;
        end else if (w_deliver) begin
            r_out_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (r_out_valid && !w_take && w_deliver) begin
            r_skid <= w_item;
        end else if (w_deliver) begin
            r_out <= w_item;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_dir_x          = r_out.dir[0];
    assign o_dir_y          = r_out.dir[1];
    assign o_dir_z          = r_out.dir[2];
    assign o_force_x        = r_out.frc[0];
    assign o_force_y        = r_out.frc[1];
    assign o_force_z        = r_out.frc[2];
    assign o_zero_magnitude = r_out.zero;
    assign o_saturated      = r_out.sat;

`ifndef SYNTH
    // The skid only fills behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // A zero-length result carries no direction and no clipping.
    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_magnitude) |->
        (o_dir_x == '0 && o_dir_y == '0 && o_dir_z == '0 && !o_saturated))
        else $error("zero-magnitude result with nonzero fields");

    // Unit direction components stay within plus or minus one in Q2.30.
    a_dir_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ($signed(o_dir_x) <= 32'sd1073741824 && $signed(o_dir_x) >= -32'sd1073741824 &&
         $signed(o_dir_y) <= 32'sd1073741824 && $signed(o_dir_y) >= -32'sd1073741824 &&
         $signed(o_dir_z) <= 32'sd1073741824 && $signed(o_dir_z) >= -32'sd1073741824))
        else $error("direction component outside unit range");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for lorentz_motion_derivative: random and directed beats are
// checked field by field against an in-bench fixed-point predictor. Depends on lmd_pkg.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [lmd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PIPE_LATENCY = 72;
    localparam int STALL_LIMIT  = 20000;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic [31:0] comp [6];  // momentum x,y,z then field x,y,z
    } t_sample;

    typedef struct {
        logic [31:0] dir [3];
        logic [31:0] frc [3];
        logic        zero;
        logic        sat;
    } t_deriv;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [lmd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_comp [6] = '{default: '0};
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_dir [3];
    logic [31:0] o_frc [3];
    logic        o_zero_magnitude;
    logic        o_saturated;

    // Shadow copy of the configuration registers.
    logic        mode_field_line = 1'b0;
    logic        reverse_dir = 1'b0;
    logic [31:0] coef_q16 = lmd_pkg::COEF_RESET;

    t_sample pending_beats [$];
    t_deriv  expected_derivs [$];
    int      error_count = 0;
    int      results_seen = 0;

    always #2 i_clk = ~i_clk;

    lorentz_motion_derivative dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_ready,
        .i_momentum_x(i_comp[0]), .i_momentum_y(i_comp[1]), .i_momentum_z(i_comp[2]),
        .i_field_x(i_comp[3]), .i_field_y(i_comp[4]), .i_field_z(i_comp[5]),
        .o_out_valid, .i_out_ready,
        .o_dir_x(o_dir[0]), .o_dir_y(o_dir[1]), .o_dir_z(o_dir[2]),
        .o_force_x(o_frc[0]), .o_force_y(o_frc[1]), .o_force_z(o_frc[2]),
        .o_zero_magnitude, .o_saturated
    );

    // Floor of the square root of a 64-bit value, digit by digit.
    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit vector in Q2.30, rounded to nearest; returns 0 for a zero-length vector.
    function automatic bit unit_vector(input logic signed [63:0] v [3],
                                       output logic signed [63:0] d [3]);
        logic [63:0] sum_sq;
        logic [63:0] len;
        logic [63:0] mag;
        logic [63:0] q;
        sum_sq = 0;
        for (int i = 0; i < 3; i++) sum_sq += 64'(v[i] * v[i]);
        if (sum_sq == 0) return 1'b0;
        len = floor_root(sum_sq);
        for (int i = 0; i < 3; i++) begin
            mag = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
            q = ((mag << 30) + (len >> 1)) / len;
            d[i] = v[i] < 0 ? -$signed(q) : $signed(q);
            if (reverse_dir) d[i] = -d[i];
        end
        return 1'b1;
    endfunction

    // coef * y / 2^46 rounded half away from zero, clipped to signed 32 bit.
    function automatic logic [31:0] scaled_force(input logic signed [63:0] y,
                                                 inout logic sat);
        logic [127:0] prod;
        logic [127:0] r;
        logic [63:0]  ym;
        logic [63:0]  cm;
        logic signed [63:0] coef;
        coef = 64'($signed(coef_q16));
        ym = y < 0 ? 64'(-y) : 64'(y);
        cm = coef < 0 ? 64'(-coef) : 64'(coef);
        prod = 128'(ym) * 128'(cm);
        r = (prod + (128'd1 << 45)) >> 46;
        if ((y < 0) != (coef < 0)) begin
            if (r > 128'h8000_0000) begin
                r = 128'h8000_0000;
                sat = 1'b1;
            end
            return 32'(-r);
        end
        if (r > 128'h7FFF_FFFF) begin
            r = 128'h7FFF_FFFF;
            sat = 1'b1;
        end
        return r[31:0];
    endfunction

    function automatic t_deriv predict_deriv(input t_sample s);
        t_deriv e;
        logic signed [63:0] p [3];
        logic signed [63:0] b [3];
        logic signed [63:0] d [3];
        logic sat;
        bit ok;
        sat = 1'b0;
        d = '{0, 0, 0};
        for (int i = 0; i < 3; i++) begin
            p[i] = 64'($signed(s.comp[i]));
            b[i] = 64'($signed(s.comp[3 + i]));
            e.frc[i] = '0;
        end
        if (mode_field_line == lmd_pkg::MODE_FIELD_LINE) begin
            ok = unit_vector(b, d);
        end else begin
            ok = unit_vector(p, d);
        end
        if (ok && mode_field_line != lmd_pkg::MODE_FIELD_LINE) begin
            e.frc[0] = scaled_force(d[1] * b[2] - d[2] * b[1], sat);
            e.frc[1] = scaled_force(d[2] * b[0] - d[0] * b[2], sat);
            e.frc[2] = scaled_force(d[0] * b[1] - d[1] * b[0], sat);
        end
        for (int i = 0; i < 3; i++) begin
            e.dir[i] = ok ? d[i][31:0] : '0;
            if (!ok) e.frc[i] = '0;
        end
        e.zero = !ok;
        e.sat = ok ? sat : 1'b0;
        return e;
    endfunction

    // One component drawn from a mix of value classes.
    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WORD_MIN;
            2: return WORD_MAX;
            3: return $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
            4: return 32'($signed($urandom) >>> $urandom_range(8, 30));
            5: return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    // Sender: bursts of random length with random gaps between them.
    int     burst_left = 0;
    int     gap_left = 0;
    always @(posedge i_clk) begin : sender
        logic   next_valid;
        t_sample s;
        next_valid = i_in_valid;
        if (i_in_valid && o_in_ready) begin
            for (int i = 0; i < 6; i++) s.comp[i] = i_comp[i];
            expected_derivs.push_back(predict_deriv(s));
            next_valid = 1'b0;
        end
        if (i_rst_n && !next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_beats.size() > 0) begin
                s = pending_beats.pop_front();
                for (int i = 0; i < 6; i++) i_comp[i] <= s.comp[i];
                next_valid = 1'b1;
                if (burst_left == 0) burst_left = $urandom_range(1, 40);
                burst_left--;
                if (burst_left == 0)
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            end
        end
        i_in_valid <= next_valid;
    end

    // Receiver: stall pattern whose mode is redrawn at random, plus one long hold-off.
    int     mode_cycles = 0;
    int     stall_mode = 0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;
    always @(posedge i_clk) begin : receiver
        t_deriv e;
        if (o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_derivs.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got dir_x %h",
                         $time, o_dir[0]);
                error_count++;
            end else begin
                e = expected_derivs.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (o_dir[i] !== e.dir[i]) begin
                        $display("%0t: dir[%0d] expected %h actual %h",
                                 $time, i, e.dir[i], o_dir[i]);
                        error_count++;
                    end
                    if (o_frc[i] !== e.frc[i]) begin
                        $display("%0t: force[%0d] expected %h actual %h",
                                 $time, i, e.frc[i], o_frc[i]);
                        error_count++;
                    end
                end
                if (o_zero_magnitude !== e.zero) begin
                    $display("%0t: zero_magnitude expected %b actual %b",
                             $time, e.zero, o_zero_magnitude);
                    error_count++;
                end
                if (o_saturated !== e.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, e.sat, o_saturated);
                    error_count++;
                end
            end
        end
        if (results_seen == 400 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
        end
        if (mode_cycles == 0) begin
            mode_cycles = 50;
            stall_mode = $urandom_range(0, 3);
        end
        mode_cycles--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= $urandom_range(0, 7) != 0;
                default: i_out_ready <= $urandom_range(0, 7) == 0;
            endcase
        end
    end

    // Watchdog: give up when neither channel has moved for too long.
    int     idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [lmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            lmd_pkg::CFG_EQUATION_MODE: mode_field_line = val[0];
            lmd_pkg::CFG_REVERSE_TIME:  reverse_dir = val[0];
            lmd_pkg::CFG_FORCE_COEF:    coef_q16 = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic mode, input logic rev, input logic [31:0] coef);
        write_reg(lmd_pkg::CFG_EQUATION_MODE, {31'($urandom), mode});
        write_reg(lmd_pkg::CFG_REVERSE_TIME, {31'($urandom), rev});
        write_reg(lmd_pkg::CFG_FORCE_COEF, coef);
        write_reg(CFG_UNUSED, $urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_beat(input logic [31:0] px, py, pz, bx, by, bz);
        t_sample s;
        s.comp = '{px, py, pz, bx, by, bz};
        pending_beats.push_back(s);
    endtask

    task automatic queue_random(input int count);
        t_sample s;
        repeat (count) begin
            for (int i = 0; i < 6; i++) s.comp[i] = random_component();
            // Occasionally a whole vector is zero.
            if ($urandom_range(0, 15) == 0) begin
                for (int i = 0; i < 3; i++) s.comp[i] = '0;
            end
            if ($urandom_range(0, 15) == 0) begin
                for (int i = 3; i < 6; i++) s.comp[i] = '0;
            end
            pending_beats.push_back(s);
        end
    endtask

    // Let every beat drain, then leave the pipeline time to settle.
    task automatic drain();
        while (pending_beats.size() > 0 || i_in_valid || expected_derivs.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset configuration.
        queue_beat(0, 0, 0, 32'h1_0000, 0, 0);
        queue_beat(0, 0, 0, 0, 0, 0);
        queue_beat(32'h1_0000, 0, 0, 0, 32'h1_0000, 0);
        queue_beat(WORD_MIN, 0, 0, 0, WORD_MAX, 0);
        queue_beat(WORD_MAX, 0, 0, 0, 0, WORD_MIN);
        queue_beat(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
        queue_beat(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        queue_beat(1, 0, 0, 0, WORD_MIN, 0);
        queue_beat(0, 32'hFFFF_FFFF, 0, WORD_MAX, 0, WORD_MAX);
        queue_beat(1, 1, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
        queue_beat(0, 0, 32'h7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Largest coefficient, backward tracing: saturating forces.
        set_config(1'b0, 1'b1, WORD_MAX);
        queue_beat(WORD_MIN, 0, 0, 0, WORD_MAX, 0);
        queue_beat(0, WORD_MAX, 0, WORD_MIN, 0, 0);
        queue_beat(0, 0, 0, WORD_MAX, WORD_MAX, WORD_MAX);
        queue_random(250);
        drain();

        // Most negative coefficient.
        set_config(1'b0, 1'b0, WORD_MIN);
        queue_beat(WORD_MAX, 0, 0, 0, WORD_MIN, 0);
        queue_beat(WORD_MAX, WORD_MAX, 0, 0, 0, WORD_MAX);
        queue_random(250);
        drain();

        // Field-line mode, both directions.
        set_config(lmd_pkg::MODE_FIELD_LINE, 1'b0, $urandom);
        queue_beat(32'h1_0000, 0, 0, 0, 0, 0);
        queue_beat(0, 0, 0, WORD_MIN, WORD_MIN, WORD_MIN);
        queue_random(250);
        drain();
        set_config(lmd_pkg::MODE_FIELD_LINE, 1'b1, $urandom);
        queue_random(250);
        drain();

        // Lorentz mode with random, zero and unit coefficients.
        set_config(1'b0, 1'b1, $urandom);
        queue_random(250);
        drain();
        set_config(1'b0, 1'b0, 32'd0);
        queue_random(100);
        drain();
        set_config(1'b0, 1'b0, lmd_pkg::COEF_RESET);
        queue_random(400);
        drain();

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lmd_pkg.sv
hw/rtl/lmd_isqrt.sv
hw/rtl/lmd_div.sv
hw/rtl/lmd_force.sv
hw/rtl/lorentz_motion_derivative.sv
bench/tb_top.sv
